// ===== rtl/core/stq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types and constants of the sorted timeout queue.
// ----------------------------------------------------------------------------
package stq_pkg;

    localparam int SLOTS     = 16;
    localparam int TIME_BITS = 32;
    localparam int TAG_BITS  = 16;
    localparam int IDX_BITS  = $clog2(SLOTS);
    localparam int PTR_BITS  = IDX_BITS + 1;
    localparam int CNT_BITS  = $clog2(SLOTS + 1);

    localparam logic [PTR_BITS-1:0] NONE_PTR = PTR_BITS'(SLOTS);

    typedef enum logic [1:0] {
        OP_CREATE = 2'd0,
        OP_REMOVE = 2'd1,
        OP_POLL   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_CREATED   = 3'd0,
        ST_FULL      = 3'd1,
        ST_REMOVED   = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_WRONG_OWN = 3'd4,
        ST_NOT_FOUND = 3'd5,
        ST_EXPIRED   = 3'd6,
        ST_NONE_DUE  = 3'd7
    } status_t;

    // One slot entry as read by the sequencer
    typedef struct packed {
        logic [TIME_BITS-1:0] deadline;
        logic [PTR_BITS-1:0]  next;
        logic [TAG_BITS-1:0]  context_tag;
        logic [TAG_BITS-1:0]  owner;
    } entry_t;

    // Write command from the sequencer to the slot table
    typedef struct packed {
        logic                 we_full;
        logic                 we_next;
        logic                 set_busy;
        logic                 clr_busy;
        logic [IDX_BITS-1:0]  addr;
        logic [TIME_BITS-1:0] deadline;
        logic [PTR_BITS-1:0]  next;
        logic [TAG_BITS-1:0]  context_tag;
        logic [TAG_BITS-1:0]  owner;
    } tbl_wr_t;

    // Result transaction
    typedef struct packed {
        status_t              status;
        logic [IDX_BITS-1:0]  slot;
        logic [TAG_BITS-1:0]  context_out;
        logic [TIME_BITS-1:0] lateness;
        logic [CNT_BITS-1:0]  active_count;
        logic                 last;
    } result_t;

endpackage

// ===== rtl/core/sorted_timeout_queue_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timeout_queue_core
// Timer queue of deadline-ordered slots kept as a linked list.
// ----------------------------------------------------------------------------
// Input channel s_axis: one transaction per create, remove or poll command.
// Output channel m_axis: result transactions; tlast marks the last result
// of a command. A poll gives one result per expired entry, else one
// "none expired" result.
// A create on a full pool and a remove on an empty list are answered as
// the command is taken. A create then checks the head, where the new entry
// may go first, else walks the list to its place and splices it in. A remove
// checks the target's owner and busy flag, answering on a wrong owner or an
// unlinked slot, else walks from the head to the target and unlinks it. A
// poll checks one entry and gives one result per cycle while results are
// taken. The walk is bounded by the single table read port. s_axis_tready
// stays low while a command is in progress or a result is pending, so the
// next command is taken the cycle after the last result leaves.
// Reset empties the list, marks all slots idle and clears the owner tags.
// When the receiver stalls, the result register holds and polling pauses.
// ----------------------------------------------------------------------------
module sorted_timeout_queue_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // operation[1:0], deadline[33:2], slot_index[37:34], owner_tag[53:38],
    // context_tag[69:54], now_time[101:70]
    input  logic [103:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0], slot[6:3], context_out[22:7], lateness[54:23],
    // active_count[59:55]
    output logic [63:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    import stq_pkg::*;

    logic [IDX_BITS-1:0] rd_addr;
    entry_t              rd_entry;
    tbl_wr_t             wr;
    logic [SLOTS-1:0]    busy;
    result_t             res;

    stq_table u_table (
        .clk(clk), .rst_n(rst_n), .rd_addr(rd_addr), .rd_entry(rd_entry),
        .wr(wr), .busy(busy)
    );

    stq_seq u_seq (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .op(op_t'(s_axis_tdata[1:0])),
        .deadline(s_axis_tdata[33:2]),
        .slot_index(s_axis_tdata[37:34]),
        .owner_tag(s_axis_tdata[53:38]),
        .context_tag(s_axis_tdata[69:54]),
        .now_time(s_axis_tdata[101:70]),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res),
        .rd_addr(rd_addr), .rd_entry(rd_entry), .wr(wr), .busy(busy)
    );

    assign m_axis_tdata = {4'd0, res.active_count, res.lateness, res.context_out,
                           res.slot, res.status};
    assign m_axis_tlast = res.last;

endmodule

// ===== rtl/core/stq_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_table
// Slot storage: deadline, link, tags and busy flags; one read port.
// ----------------------------------------------------------------------------
module stq_table (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [stq_pkg::IDX_BITS-1:0] rd_addr,
    output stq_pkg::entry_t         rd_entry,
    input  stq_pkg::tbl_wr_t        wr,
    output logic [stq_pkg::SLOTS-1:0] busy
);
    import stq_pkg::*;

    logic [TIME_BITS-1:0] deadline_mem [SLOTS];
    logic [PTR_BITS-1:0]  next_mem     [SLOTS];
    logic [TAG_BITS-1:0]  context_mem  [SLOTS];
    logic [TAG_BITS-1:0]  owner_reg    [SLOTS];
    logic [SLOTS-1:0]     busy_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we_full)
        begin
            deadline_mem[wr.addr] <= wr.deadline;
            context_mem[wr.addr]  <= wr.context_tag;
        end
        if (wr.we_full || wr.we_next)
            next_mem[wr.addr] <= wr.next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
            for (int i = 0; i < SLOTS; i++)
                owner_reg[i] <= '0;
        end
        else
        begin
            if (wr.we_full)
                owner_reg[wr.addr] <= wr.owner;
            if (wr.set_busy)
                busy_reg[wr.addr] <= 1'b1;
            else if (wr.clr_busy)
                busy_reg[wr.addr] <= 1'b0;
        end
    end

    assign rd_entry.deadline    = deadline_mem[rd_addr];
    assign rd_entry.next        = next_mem[rd_addr];
    assign rd_entry.context_tag = context_mem[rd_addr];
    assign rd_entry.owner       = owner_reg[rd_addr];
    assign busy = busy_reg;

endmodule

// ===== rtl/core/stq_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_seq
// Sequencer: walks entries one per cycle unless a poll stalls; shared compare unit.
// ----------------------------------------------------------------------------
module stq_seq (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  stq_pkg::op_t            op,
    input  logic [stq_pkg::TIME_BITS-1:0] deadline,
    input  logic [stq_pkg::IDX_BITS-1:0]  slot_index,
    input  logic [stq_pkg::TAG_BITS-1:0]  owner_tag,
    input  logic [stq_pkg::TAG_BITS-1:0]  context_tag,
    input  logic [stq_pkg::TIME_BITS-1:0] now_time,
    output logic                    res_valid,
    input  logic                    res_ready,
    output stq_pkg::result_t        res,
    output logic [stq_pkg::IDX_BITS-1:0] rd_addr,
    input  stq_pkg::entry_t         rd_entry,
    output stq_pkg::tbl_wr_t        wr,
    input  logic [stq_pkg::SLOTS-1:0] busy
);
    import stq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_CR_HEAD, S_CR_WALK, S_RM_WALK, S_POLL, S_OUT
    } state_t;

    state_t               state_reg;
    op_t                  op_reg;
    logic [TIME_BITS-1:0] key_reg;      // deadline, owner tag or now_time
    logic [IDX_BITS-1:0]  tgt_reg;      // new slot or slot to remove
    logic [PTR_BITS-1:0]  cur_reg;
    logic [PTR_BITS-1:0]  prev_reg;
    logic [PTR_BITS-1:0]  head_reg;
    logic [PTR_BITS-1:0]  tnext_reg;    // link of the slot being removed
    logic [CNT_BITS-1:0]  count_reg;
    logic                 rm_patch_reg; // remove: 0 checks the target, 1 walks
    logic                 poll_any_reg;
    result_t              pend_reg;     // popped entry, held until its tlast is known
    result_t              res_reg;
    logic                 res_valid_reg;

    logic                 key_lt;
    logic [TIME_BITS-1:0] diff;
    logic [IDX_BITS-1:0]  free_idx;
    logic                 free_found;
    logic [IDX_BITS-1:0]  cur_idx;
    logic                 res_ready_ok;
    logic                 walk_stop;
    logic                 poll_due;
    logic                 rm_hit;
    logic                 rm_bad_owner;
    logic                 res_load;

    // Shared unit: compare and subtract against the entry being read
    assign key_lt = key_reg < rd_entry.deadline;
    assign diff   = key_reg - rd_entry.deadline;

    // Lowest idle slot
    always_comb
    begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!busy[i])
            begin
                free_idx   = IDX_BITS'(i);
                free_found = 1'b1;
            end
        end
    end

    assign cur_idx      = cur_reg[IDX_BITS-1:0];
    assign rd_addr      = cur_idx;
    assign res_ready_ok = !res_valid_reg || res_ready;
    assign walk_stop    = cur_reg[IDX_BITS] || !(rd_entry.deadline < key_reg);
    assign poll_due     = !cur_reg[IDX_BITS] && key_lt == 1'b0 && rd_entry.deadline < key_reg;
    assign rm_hit       = rm_patch_reg && (cur_reg == PTR_BITS'(tgt_reg));
    assign rm_bad_owner = rd_entry.owner != key_reg[TAG_BITS-1:0];

    assign in_ready  = (state_reg == S_IDLE) && !res_valid_reg;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    function automatic result_t mk(status_t st, logic [IDX_BITS-1:0] sl,
                                   logic [TAG_BITS-1:0] cx, logic [TIME_BITS-1:0] lt,
                                   logic [CNT_BITS-1:0] cn, logic la);
        result_t r;
        r.status = st; r.slot = sl; r.context_out = cx;
        r.lateness = lt; r.active_count = cn; r.last = la;
        return r;
    endfunction

    // A new result enters the output register this cycle
    always_comb
    begin
        res_load = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                res_load = in_valid && in_ready &&
                           ((op == OP_CREATE && !free_found) ||
                            (op == OP_REMOVE && head_reg[IDX_BITS]));
            end
            S_CR_HEAD: res_load = head_reg[IDX_BITS] || key_lt;
            S_RM_WALK: res_load = !rm_patch_reg && (rm_bad_owner || !busy[tgt_reg]);
            S_POLL:    res_load = res_ready_ok && (!poll_due || poll_any_reg);
            S_OUT:     res_load = 1'b1;
            default:   res_load = 1'b0;
        endcase
    end

    always_comb
    begin
        wr = '0;
        wr.addr = tgt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready && op == OP_CREATE && free_found)
                begin
                    wr.we_full     = 1'b1;
                    wr.set_busy    = 1'b1;
                    wr.addr        = free_idx;
                    wr.deadline    = deadline;
                    wr.context_tag = context_tag;
                    wr.owner       = owner_tag;
                    wr.next        = NONE_PTR;
                end
            end
            S_CR_HEAD:
            begin
                // Reading head entry
                if (head_reg[IDX_BITS] || key_lt)
                begin
                    wr.we_next = 1'b1;
                    wr.next    = head_reg;
                end
            end
            S_CR_WALK:
            begin
                // Reading entry cur; prev_reg is its predecessor
                if (walk_stop)
                begin
                    wr.we_next = 1'b1;
                    wr.addr    = prev_reg[IDX_BITS-1:0];
                    wr.next    = PTR_BITS'(tgt_reg);
                end
            end
            S_OUT:
            begin
                if (op_reg == OP_CREATE)
                begin
                    // Finish the create splice: new entry points at cur
                    wr.we_next = 1'b1;
                    wr.next    = cur_reg;
                end
                else if (!prev_reg[IDX_BITS])
                begin
                    // Bypass the removed entry
                    wr.we_next = 1'b1;
                    wr.addr    = prev_reg[IDX_BITS-1:0];
                    wr.next    = tnext_reg;
                end
            end
            S_RM_WALK:
            begin
                if (rm_hit)
                    wr.clr_busy = 1'b1;
            end
            S_POLL:
            begin
                if (res_ready_ok && poll_due)
                begin
                    wr.clr_busy = 1'b1;
                    wr.addr     = cur_idx;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= NONE_PTR;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
            op_reg        <= OP_NONE;
            poll_any_reg  <= 1'b0;
            rm_patch_reg  <= 1'b0;
            key_reg       <= '0;
            tgt_reg       <= '0;
            cur_reg       <= NONE_PTR;
            prev_reg      <= NONE_PTR;
            tnext_reg     <= NONE_PTR;
            pend_reg      <= '0;
            res_reg       <= '0;
        end
        else
        begin
            res_valid_reg <= res_load || (res_valid_reg && !res_ready);
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        op_reg <= op;
                        unique case (op)
                            OP_CREATE:
                            begin
                                key_reg <= deadline;
                                if (!free_found)
                                    res_reg <= mk(ST_FULL, '0, '0, '0, count_reg, 1'b1);
                                else
                                begin
                                    tgt_reg   <= free_idx;
                                    count_reg <= count_reg + CNT_BITS'(1);
                                    cur_reg   <= head_reg;
                                    state_reg <= S_CR_HEAD;
                                end
                            end
                            OP_REMOVE:
                            begin
                                tgt_reg <= slot_index;
                                key_reg <= TIME_BITS'(owner_tag);
                                if (head_reg[IDX_BITS])
                                    res_reg <= mk(ST_EMPTY, '0, '0, '0, count_reg, 1'b1);
                                else
                                begin
                                    cur_reg      <= PTR_BITS'(slot_index);
                                    prev_reg     <= NONE_PTR;
                                    state_reg    <= S_RM_WALK;
                                    rm_patch_reg <= 1'b0;
                                end
                            end
                            OP_POLL:
                            begin
                                key_reg      <= now_time;
                                cur_reg      <= head_reg;
                                poll_any_reg <= 1'b0;
                                state_reg    <= S_POLL;
                            end
                            default: ;
                        endcase
                    end
                end
                S_CR_HEAD:
                begin
                    if (head_reg[IDX_BITS] || key_lt)
                    begin
                        head_reg  <= PTR_BITS'(tgt_reg);
                        res_reg   <= mk(ST_CREATED, tgt_reg, '0, '0, count_reg, 1'b1);
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        prev_reg  <= head_reg;
                        cur_reg   <= rd_entry.next;
                        state_reg <= S_CR_WALK;
                    end
                end
                S_CR_WALK:
                begin
                    if (walk_stop)
                        state_reg <= S_OUT;
                    else
                    begin
                        prev_reg <= cur_reg;
                        cur_reg  <= rd_entry.next;
                    end
                end
                S_OUT:
                begin
                    if (op_reg == OP_CREATE)
                        res_reg <= mk(ST_CREATED, tgt_reg, '0, '0, count_reg, 1'b1);
                    else
                        res_reg <= mk(ST_REMOVED, tgt_reg, '0, '0, count_reg, 1'b1);
                    state_reg <= S_IDLE;
                end
                S_RM_WALK:
                begin
                    if (!rm_patch_reg)
                    begin
                        // First step reads the target slot: owner and link
                        if (rm_bad_owner)
                        begin
                            res_reg   <= mk(ST_WRONG_OWN, '0, '0, '0, count_reg, 1'b1);
                            state_reg <= S_IDLE;
                        end
                        else if (!busy[tgt_reg])
                        begin
                            res_reg   <= mk(ST_NOT_FOUND, '0, '0, '0, count_reg, 1'b1);
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            tnext_reg    <= rd_entry.next;
                            rm_patch_reg <= 1'b1;
                            cur_reg      <= head_reg;
                        end
                    end
                    else if (rm_hit)
                    begin
                        if (prev_reg[IDX_BITS])
                            head_reg <= tnext_reg;
                        count_reg <= count_reg - CNT_BITS'(1);
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        prev_reg <= cur_reg;
                        cur_reg  <= rd_entry.next;
                    end
                end
                S_POLL:
                begin
                    if (res_ready_ok)
                    begin
                        if (poll_due)
                        begin
                            // Pop the head; release the previous pop as not last
                            pend_reg     <= mk(ST_EXPIRED, cur_idx, rd_entry.context_tag,
                                               diff, count_reg - CNT_BITS'(1), 1'b0);
                            if (poll_any_reg)
                                res_reg <= pend_reg;
                            head_reg     <= rd_entry.next;
                            cur_reg      <= rd_entry.next;
                            count_reg    <= count_reg - CNT_BITS'(1);
                            poll_any_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                            if (poll_any_reg)
                                res_reg <= mk(pend_reg.status, pend_reg.slot,
                                              pend_reg.context_out, pend_reg.lateness,
                                              pend_reg.active_count, 1'b1);
                            else
                                res_reg <= mk(ST_NONE_DUE, '0, '0, '0, count_reg, 1'b1);
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(SLOTS)) else $error("count overflow");
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg[IDX_BITS] |-> (head_reg == NONE_PTR)) else $error("bad head");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && op != OP_NONE) |=> !in_ready)
        else $error("ready while busy");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res)))
        else $error("result changed while stalled");
`endif

endmodule
